// ----- src/pmms_pkg.sv -----
// ----------------------------------------------------------------------------
// pmms_pkg
// Shared types, field widths and codes for the process mailbox message store.
// ----------------------------------------------------------------------------
package pmms_pkg;

    // item field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int LEN_W    = 8;
    localparam int DATA_W   = 64;
    localparam int SIZE_W   = 4;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 4;

    // defaults for the top-level parameters
    localparam int DEF_MAILBOXES     = 16;
    localparam int DEF_SLOTS         = 8;
    localparam int DEF_MESSAGE_BYTES = 8;
    localparam int DEF_SYSTEM_ID     = 0;

    // size of an error record pushed into the system mailbox
    localparam logic [SIZE_W-1:0] ERR_RECORD_BYTES = SIZE_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_SEND  = 2'd0,
        OP_GET   = 2'd1,
        OP_CHECK = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_BAD_SRC   = 3'd1,
        STS_BAD_DST   = 3'd2,
        STS_OVERSIZED = 3'd3,
        STS_OVERFLOW  = 3'd4,
        STS_BAD_RCV   = 3'd5,
        STS_EMPTY     = 3'd6
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic exec;   // item accepted: decide, update counts, access slot store
        logic load;   // move result into the output register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;   // output register holds a result not yet taken
    } t_dp_status;

endpackage

// ----- src/pmms_ctrl.sv -----
// ----------------------------------------------------------------------------
// pmms_ctrl
// Two-state sequencer: accept and execute an item, then hand its result to
// the output register once that register is free or being taken.
// ----------------------------------------------------------------------------
module pmms_ctrl
    import pmms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_RESP;
                end
            end
            S_RESP: begin
                // slot read data is registered by now
                if (!i_status.out_busy || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/pmms_datapath.sv -----
// ----------------------------------------------------------------------------
// pmms_datapath
// Per-mailbox stack counts, the slot store and the output register.
// ----------------------------------------------------------------------------
module pmms_datapath
    import pmms_pkg::*;
#(
    parameter int MAILBOXES     = DEF_MAILBOXES,
    parameter int SLOTS         = DEF_SLOTS,
    parameter int MESSAGE_BYTES = DEF_MESSAGE_BYTES,
    parameter int SYSTEM_ID     = DEF_SYSTEM_ID
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ID_W-1:0]     i_sender,
    input  logic [ID_W-1:0]     i_receiver,
    input  logic [LEN_W-1:0]    i_length,
    input  logic [DATA_W-1:0]   i_payload,
    input  logic                i_out_ready,
    output t_dp_status          o_status,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_res_status,
    output logic                o_res_available,
    output logic [ID_W-1:0]     o_res_source,
    output logic [SIZE_W-1:0]   o_res_size,
    output logic [DATA_W-1:0]   o_res_payload
);

    localparam int BW    = $clog2(MAILBOXES);
    localparam int DEPTH = MAILBOXES * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = ID_W + SIZE_W + DATA_W;

    localparam bit SysOk = (SYSTEM_ID < MAILBOXES);
    localparam logic [BW-1:0] SysIdx   = BW'(SYSTEM_ID);
    localparam logic [ID_W-1:0] SysSrc = ID_W'(SYSTEM_ID);

    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] d,
                                                     input logic [SIZE_W-1:0] n);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (SIZE_W'(b) < n) begin
                r[8*b +: 8] = d[8*b +: 8];
            end
        end
        return r;
    endfunction

    // per-mailbox stack depth
    logic [CNT_W-1:0] r_count [MAILBOXES];
    // slot store, word = {source, size, payload}
    logic [SW-1:0]    r_mem [DEPTH];
    logic [SW-1:0]    r_rd;

    logic             r_res_pop;
    t_status          r_res_st;
    logic             r_res_avail;

    logic             r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic             r_o_avail;
    logic [ID_W-1:0]  r_o_source;
    logic [SIZE_W-1:0] r_o_size;
    logic [DATA_W-1:0] r_o_payload;

    logic [BW-1:0]    dst_idx;
    logic [CNT_W-1:0] dst_cnt;
    logic [CNT_W-1:0] sys_cnt;
    logic             src_ok;
    logic             dst_ok;
    logic             len_ok;

    t_status          st;
    logic             avail;
    logic             pop;
    logic             err;
    logic [ID_W-1:0]  err_src;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [SW-1:0]    mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             cnt_we;
    logic [BW-1:0]    cnt_idx;
    logic [CNT_W-1:0] cnt_wdata;

    assign dst_idx = i_receiver[BW-1:0];
    assign dst_cnt = r_count[dst_idx];
    assign sys_cnt = r_count[SysIdx];
    assign src_ok  = (32'(i_sender) < MAILBOXES);
    assign dst_ok  = (32'(i_receiver) < MAILBOXES);
    assign len_ok  = (32'(i_length) <= MESSAGE_BYTES);

    always_comb begin
        st        = STS_OK;
        avail     = 1'b0;
        pop       = 1'b0;
        err       = 1'b0;
        err_src   = i_sender;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = AW'(dst_idx) * AW'(SLOTS) + AW'(dst_cnt - 1'b1);
        cnt_we    = 1'b0;
        cnt_idx   = dst_idx;
        cnt_wdata = dst_cnt;

        case (t_op'(i_op))
            OP_SEND: begin
                if (!src_ok) begin
                    st      = STS_BAD_SRC;
                    err     = 1'b1;
                    err_src = SysSrc;
                end else if (!dst_ok) begin
                    st  = STS_BAD_DST;
                    err = 1'b1;
                end else if (!len_ok) begin
                    st  = STS_OVERSIZED;
                    err = 1'b1;
                end else if (32'(dst_cnt) >= SLOTS) begin
                    st  = STS_OVERFLOW;
                    err = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(dst_idx) * AW'(SLOTS) + AW'(dst_cnt);
                    mem_wdata = {i_sender, i_length[SIZE_W-1:0],
                                 keep_bytes(i_payload, i_length[SIZE_W-1:0])};
                    cnt_we    = 1'b1;
                    cnt_wdata = dst_cnt + 1'b1;
                end

                // error record into the system mailbox
                if (err && SysOk) begin
                    mem_we  = 1'b1;
                    if (32'(sys_cnt) >= SLOTS) begin
                        // full: overwrite the top slot, count unchanged
                        mem_waddr = AW'(SysIdx) * AW'(SLOTS) + AW'(SLOTS - 1);
                        mem_wdata = {{ID_W{1'b0}}, ERR_RECORD_BYTES,
                                     DATA_W'(STS_OVERFLOW)};
                    end else begin
                        mem_waddr = AW'(SysIdx) * AW'(SLOTS) + AW'(sys_cnt);
                        mem_wdata = {err_src, ERR_RECORD_BYTES, DATA_W'(st)};
                        cnt_we    = 1'b1;
                        cnt_idx   = SysIdx;
                        cnt_wdata = sys_cnt + 1'b1;
                    end
                end
            end
            OP_GET: begin
                if (!dst_ok) begin
                    st = STS_BAD_RCV;
                end else if (dst_cnt == '0) begin
                    st = STS_EMPTY;
                end else begin
                    pop       = 1'b1;
                    mem_re    = 1'b1;
                    cnt_we    = 1'b1;
                    cnt_wdata = dst_cnt - 1'b1;
                end
            end
            OP_CHECK: begin
                avail = dst_ok && (dst_cnt != '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MAILBOXES; b++) begin
                r_count[b] <= '0;
            end
        end else if (i_cmd.exec && cnt_we) begin
            r_count[cnt_idx] <= cnt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.exec && mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_st    <= st;
            r_res_avail <= avail;
            r_res_pop   <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status  <= r_res_st;
            r_o_avail   <= r_res_avail;
            r_o_source  <= r_res_pop ? r_rd[SW-1 -: ID_W] : '0;
            r_o_size    <= r_res_pop ? r_rd[DATA_W +: SIZE_W] : '0;
            r_o_payload <= r_res_pop ? r_rd[DATA_W-1:0] : '0;
        end
    end

    assign o_status.out_busy = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_res_status      = r_o_status;
    assign o_res_available   = r_o_avail;
    assign o_res_source      = r_o_source;
    assign o_res_size        = r_o_size;
    assign o_res_payload     = r_o_payload;

endmodule

// ----- src/process_mailbox_message_store_top.sv -----
// An accepted item updates the stack counts and the slot store and registers its result and
// its slot read; in the response state the result is loaded into the output register
// once that register is free or being taken. No new item is accepted before that load.
// The output register lets the next item be accepted
// while a result waits. Reset clears all stack counts, the control state and the output
// valid flag; the slot store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// process_mailbox_message_store_top
// Per-process LIFO message mailboxes with error reporting to a system mailbox.
// ----------------------------------------------------------------------------
module process_mailbox_message_store_top
    import pmms_pkg::*;
#(
    parameter int MAILBOXES     = DEF_MAILBOXES,
    parameter int SLOTS         = DEF_SLOTS,
    parameter int MESSAGE_BYTES = DEF_MESSAGE_BYTES,
    parameter int SYSTEM_ID     = DEF_SYSTEM_ID
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] sender_id, [15:8] receiver_id, [23:16] msg_length, [87:24] payload
    input  logic [87:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [3] available, [11:4] msg_source, [15:12] msg_size,
    // [79:16] msg_payload
    output logic [79:0] m_axis_tdata
);

    t_ctrl_cmd  cmd;
    t_dp_status dp_status;

    logic [STATUS_W-1:0] res_status;
    logic                res_available;
    logic [ID_W-1:0]     res_source;
    logic [SIZE_W-1:0]   res_size;
    logic [DATA_W-1:0]   res_payload;

    pmms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (dp_status),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd)
    );

    pmms_datapath #(
        .MAILBOXES     (MAILBOXES),
        .SLOTS         (SLOTS),
        .MESSAGE_BYTES (MESSAGE_BYTES),
        .SYSTEM_ID     (SYSTEM_ID)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (s_axis_tuser),
        .i_sender        (s_axis_tdata[7:0]),
        .i_receiver      (s_axis_tdata[15:8]),
        .i_length        (s_axis_tdata[23:16]),
        .i_payload       (s_axis_tdata[87:24]),
        .i_out_ready     (m_axis_tready),
        .o_status        (dp_status),
        .o_out_valid     (m_axis_tvalid),
        .o_res_status    (res_status),
        .o_res_available (res_available),
        .o_res_source    (res_source),
        .o_res_size      (res_size),
        .o_res_payload   (res_payload)
    );

    assign m_axis_tdata = {res_payload, res_size, res_source, res_available, res_status};

endmodule

// ----- tb/tb_process_mailbox_message_store_top.sv -----
// ----------------------------------------------------------------------------
// tb_process_mailbox_message_store_top
// Self-checking bench for the mailbox message store. A directed table walks
// the id, size and status corners, then random fill and drain phases run
// against a behavioral model of the per-process LIFO stacks and the system
// error mailbox. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_process_mailbox_message_store_top;
    import pmms_pkg::*;

    localparam int MAILBOXES     = DEF_MAILBOXES;
    localparam int SLOTS         = DEF_SLOTS;
    localparam int MESSAGE_BYTES = DEF_MESSAGE_BYTES;
    localparam int SYSTEM_ID     = DEF_SYSTEM_ID;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int DIR_ROWS     = 25;
    localparam int RANDOM_ITEMS = 1025;
    localparam int PHASE_ITEMS  = 75;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [ID_W-1:0]   dst;
        logic [ID_W-1:0]   src;
    } t_request;

    // same layout as m_axis_tdata, status in the low bits
    typedef struct packed {
        logic [DATA_W-1:0]   payload;
        logic [SIZE_W-1:0]   size;
        logic [ID_W-1:0]     src;
        logic                avail;
        logic [STATUS_W-1:0] status;
    } t_reply;

    typedef struct packed {
        t_request rq;
        logic     fixed;   // reply typed in below, not predicted
        t_reply   reply;
    } t_dir_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [87:0]   s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [79:0]   m_axis_tdata;

    // model state
    logic [CNT_W-1:0]  box_count [MAILBOXES];
    logic [ID_W-1:0]   slot_src  [MAILBOXES*SLOTS];
    logic [SIZE_W-1:0] slot_size [MAILBOXES*SLOTS];
    logic [DATA_W-1:0] slot_data [MAILBOXES*SLOTS];

    t_reply   pending_replies [$];
    t_dir_row dir_rows [DIR_ROWS];
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    bit       send_idling = 1'b1;
    bit       take_idling = 1'b1;

    process_mailbox_message_store_top #(
        .MAILBOXES     (MAILBOXES),
        .SLOTS         (SLOTS),
        .MESSAGE_BYTES (MESSAGE_BYTES),
        .SYSTEM_ID     (SYSTEM_ID)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] keep_bytes(logic [DATA_W-1:0] d, int n);
        if (n >= 8)
            return d;
        return d & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic void store_slot(int box, int pos, logic [ID_W-1:0] src,
                                       int size, logic [DATA_W-1:0] d);
        int idx;
        idx = box * SLOTS + pos;
        slot_src[idx]  = src;
        slot_size[idx] = SIZE_W'(size);
        slot_data[idx] = keep_bytes(d, size);
    endfunction

    // error record into the system mailbox; a full one gets its top overwritten
    function automatic void log_fault(logic [ID_W-1:0] src, t_status code);
        int n;
        if (SYSTEM_ID >= MAILBOXES)
            return;
        n = box_count[SYSTEM_ID];
        if (n >= SLOTS) begin
            store_slot(SYSTEM_ID, SLOTS - 1, '0, ERR_RECORD_BYTES, DATA_W'(STS_OVERFLOW));
        end else begin
            store_slot(SYSTEM_ID, n, src, ERR_RECORD_BYTES, DATA_W'(code));
            box_count[SYSTEM_ID] = CNT_W'(n + 1);
        end
    endfunction

    function automatic t_reply mailbox_apply(t_request rq);
        t_reply rp;
        int     n;
        int     idx;
        rp = '0;
        case (rq.op)
            OP_SEND: begin
                if (rq.src >= MAILBOXES) begin
                    rp.status = STS_BAD_SRC;
                    log_fault(ID_W'(SYSTEM_ID), STS_BAD_SRC);
                end else if (rq.dst >= MAILBOXES) begin
                    rp.status = STS_BAD_DST;
                    log_fault(rq.src, STS_BAD_DST);
                end else if (rq.len > MESSAGE_BYTES) begin
                    rp.status = STS_OVERSIZED;
                    log_fault(rq.src, STS_OVERSIZED);
                end else if (box_count[rq.dst] >= SLOTS) begin
                    rp.status = STS_OVERFLOW;
                    log_fault(rq.src, STS_OVERFLOW);
                end else begin
                    n = box_count[rq.dst];
                    store_slot(rq.dst, n, rq.src, rq.len, rq.data);
                    box_count[rq.dst] = CNT_W'(n + 1);
                end
            end
            OP_GET: begin
                if (rq.dst >= MAILBOXES) begin
                    rp.status = STS_BAD_RCV;
                end else if (box_count[rq.dst] == 0) begin
                    rp.status = STS_EMPTY;
                end else begin
                    n   = box_count[rq.dst] - 1;
                    idx = rq.dst * SLOTS + n;
                    rp.src     = slot_src[idx];
                    rp.size    = slot_size[idx];
                    rp.payload = keep_bytes(slot_data[idx], slot_size[idx]);
                    box_count[rq.dst] = CNT_W'(n);
                end
            end
            OP_CHECK: begin
                rp.avail = (rq.dst < MAILBOXES) && (box_count[rq.dst] != 0);
            end
            default: ;
        endcase
        return rp;
    endfunction

    function automatic t_dir_row mk_row(logic [OP_W-1:0] op, int src, int dst, int len,
                                        logic [DATA_W-1:0] d, bit fixed,
                                        t_status st, bit avail);
        t_dir_row r;
        r.rq.op        = op;
        r.rq.src       = ID_W'(src);
        r.rq.dst       = ID_W'(dst);
        r.rq.len       = LEN_W'(len);
        r.rq.data      = d;
        r.fixed        = fixed;
        r.reply        = '0;
        r.reply.status = st;
        r.reply.avail  = avail;
        return r;
    endfunction

    // ids mostly in a few boxes so stacks fill up and overflow
    function automatic logic [ID_W-1:0] busy_box();
        if ($urandom_range(0, 1) != 0)
            return ID_W'($urandom_range(0, 3));
        return ID_W'($urandom_range(0, MAILBOXES - 1));
    endfunction

    function automatic t_request random_request(bit filling);
        t_request rq;
        int       pick;
        pick    = $urandom_range(0, 99);
        rq.data = {$urandom, $urandom};
        rq.op   = OP_SEND;
        rq.src  = ID_W'($urandom_range(0, MAILBOXES - 1));
        rq.dst  = busy_box();
        rq.len  = LEN_W'($urandom_range(0, MESSAGE_BYTES));
        if (pick < 12) begin
            // noise: anything the fields allow
            rq.op  = OP_W'($urandom_range(0, 3));
            rq.src = ID_W'($urandom_range(0, 255));
            rq.dst = ID_W'($urandom_range(0, 255));
            rq.len = LEN_W'($urandom_range(0, 255));
        end else if (pick < (filling ? 72 : 32)) begin
            rq.op = OP_SEND;
        end else if (pick < 90) begin
            rq.op = OP_GET;
        end else begin
            rq.op  = OP_CHECK;
            rq.dst = ID_W'($urandom_range(0, MAILBOXES + 1));
        end
        return rq;
    endfunction

    // valid stays high across back-to-back items, so only one update per step
    task automatic push_item(input t_request rq, input bit fixed, input t_reply lit);
        int     gap;
        t_reply rp;
        gap = send_idling ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.data, rq.len, rq.dst, rq.src};
        s_axis_tuser  <= rq.op;
        do @(posedge i_clk); while (!s_axis_tready);
        rp = mailbox_apply(rq);
        pending_replies.push_back(fixed ? lit : rp);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : reply_checker
        int     stall;
        t_reply got;
        t_reply want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = take_idling ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = m_axis_tdata;
            if (pending_replies.size() == 0) begin
                $error("reply with nothing pending: %h", got);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatch_count++;
                end
                if (got.avail !== want.avail) begin
                    $error("available: expected %0d, got %0d", want.avail, got.avail);
                    mismatch_count++;
                end
                if (got.src !== want.src) begin
                    $error("msg_source: expected %0d, got %0d", want.src, got.src);
                    mismatch_count++;
                end
                if (got.size !== want.size) begin
                    $error("msg_size: expected %0d, got %0d", want.size, got.size);
                    mismatch_count++;
                end
                if (got.payload !== want.payload) begin
                    $error("msg_payload: expected %h, got %h", want.payload, got.payload);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int     i;
        int     phase;
        int     issued;
        bit     filling;
        t_reply no_reply;
        no_reply = '0;
        foreach (box_count[b])
            box_count[b] = '0;

        dir_rows = '{
            // after reset: nothing stored
            mk_row(OP_CHECK,  0,   0,   0,   '0, 1, STS_OK,        0),
            mk_row(OP_GET,    5,   5,   0,   '0, 1, STS_EMPTY,     0),
            mk_row(OP_GET,    0,  16,   0,   '0, 1, STS_BAD_RCV,   0),
            mk_row(OP_GET,  255, 255, 255,   '1, 1, STS_BAD_RCV,   0),
            mk_row(OP_CHECK, 255, 255,  0,   '0, 1, STS_OK,        0),
            mk_row(OP_UNUSED, 255, 255, 255, '1, 1, STS_OK,        0),
            // send errors, each logged into the system mailbox
            mk_row(OP_SEND, 255,   3,   4,   '1, 1, STS_BAD_SRC,   0),
            mk_row(OP_SEND,  16,   3,   4,   '1, 1, STS_BAD_SRC,   0),
            mk_row(OP_SEND,   3,  16,   4,   '1, 1, STS_BAD_DST,   0),
            mk_row(OP_SEND,  15,  15,   9,   '1, 1, STS_OVERSIZED, 0),
            mk_row(OP_SEND,   1,  15, 255,   '1, 1, STS_OVERSIZED, 0),
            // full length and zero length at the top id
            mk_row(OP_SEND,  15,  15,   8,   '1, 1, STS_OK,        0),
            mk_row(OP_SEND,   0,  15,   0,   '1, 1, STS_OK,        0),
            mk_row(OP_GET,    0,  15,   0,   '0, 0, STS_OK,        0),
            mk_row(OP_GET,    0,  15,   0,   '0, 0, STS_OK,        0),
            mk_row(OP_SEND,   2,   7,   3, 64'hA5C3_1E7F_0B96_D248, 0, STS_OK, 0),
            mk_row(OP_GET,    9,   7,   0,   '0, 0, STS_OK,        0),
            mk_row(OP_CHECK,  0,   0,   0,   '0, 0, STS_OK,        0),
            mk_row(OP_GET,    0,   0,   0,   '0, 0, STS_OK,        0),
            // fill the system mailbox, then overwrite its top record
            mk_row(OP_SEND,   0, 200,   1,   '0, 1, STS_BAD_DST,   0),
            mk_row(OP_SEND,   4,   4, 200,   '0, 1, STS_OVERSIZED, 0),
            mk_row(OP_SEND, 128,   1,   1,   '0, 1, STS_BAD_SRC,   0),
            mk_row(OP_SEND,  14,  17,   2,   '0, 1, STS_BAD_DST,   0),
            mk_row(OP_SEND,  14,  14,  10,   '0, 1, STS_OVERSIZED, 0),
            mk_row(OP_GET,    0,   0,   0,   '0, 0, STS_OK,        0)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_ROWS; i++)
            push_item(dir_rows[i].rq, dir_rows[i].fixed, dir_rows[i].reply);

        // fill/drain-heavy phases in turn; 3rd sends and 4th takes without idling
        issued = 0;
        phase  = 0;
        while (issued < RANDOM_ITEMS) begin
            filling     = (phase % 2) == 0;
            send_idling = (phase % 3) != 2;
            take_idling = (phase % 4) != 3;
            for (i = 0; i < PHASE_ITEMS && issued < RANDOM_ITEMS; i++) begin
                push_item(random_request(filling), 1'b0, no_reply);
                issued++;
            end
            phase++;
        end
        s_axis_tvalid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
src/pmms_pkg.sv
src/pmms_ctrl.sv
src/pmms_datapath.sv
src/process_mailbox_message_store_top.sv
tb/tb_process_mailbox_message_store_top.sv
